/* sv/sfa_pkg.sv */
package sfa_pkg;

	localparam int ADDR_BITS_DEF  = 16;
	localparam int MAX_HOLES_DEF  = 16;
	localparam int MAX_ALLOCS_DEF = 32;
	localparam int MAX_GROUP_DEF  = 8;

	localparam int ADDR_W = 16;
	localparam int SIZE_W = 17;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_ADD   = 2'd1;
	localparam logic [1:0] KIND_SEG   = 2'd2;
	localparam logic [1:0] KIND_FREE  = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOFIT    = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_BADRANGE = 3'd4;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] size;
		logic              last_of_group;
		logic              policy;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [ADDR_W-1:0] seg_addr;
		logic [2:0]        seg_index;
		logic              last;
	} rsp_t;

endpackage

/* sv/sfa_ram.sv */
module sfa_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 33
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* sv/segment_fit_allocator.sv */
// One request at a time: in_stall holds off new requests until the block is back in
// S_IDLE and its last result has been taken. Each scan walks a table memory one
// entry per cycle through its single read port.
// Reset: valid bits, staged count, state and output valid clear; mem_size to 65536.
// Table memories hold no reset value; hole and alloc entries count only while valid.
module segment_fit_allocator
	import sfa_pkg::*;
#(
	parameter int ADDR_BITS  = ADDR_BITS_DEF,
	parameter int MAX_HOLES  = MAX_HOLES_DEF,
	parameter int MAX_ALLOCS = MAX_ALLOCS_DEF,
	parameter int MAX_GROUP  = MAX_GROUP_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [SIZE_W-1:0]  cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  sfa_pkg::req_t      in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output sfa_pkg::rsp_t      out_data
);
	import sfa_pkg::*;

	localparam int HW = $clog2(MAX_HOLES);
	localparam int AW = $clog2(MAX_ALLOCS);
	localparam int GW = $clog2(MAX_GROUP + 1);
	localparam int HC = $clog2(MAX_HOLES + 1);
	localparam int AC = $clog2(MAX_ALLOCS + 1);
	localparam int EW = SIZE_W + 1;
	localparam int LW = (ADDR_BITS + 1 > EW) ? ADDR_BITS + 1 : EW;

	typedef enum logic [4:0] {
		S_IDLE, S_AH_SCAN, S_AH_ASCAN, S_INS, S_INS_WR, S_INS_WR2,
		S_FR_SCAN, S_FR_DONE, S_GRP_CNT, S_GRP_COPY, S_GRP_SEG, S_GRP_PICK,
		S_GRP_COMMIT, S_GRP_EMIT, S_EMIT1
	} state_t;

	state_t state_q;

	// hole memory: {start, size}; working copy is a second memory of the same shape
	logic              h_we, w_we;
	logic [HW-1:0]     h_wa, h_ra, w_wa, w_ra;
	logic [ADDR_W+SIZE_W-1:0] h_wd, h_rd, w_wd, w_rd;
	logic [MAX_HOLES-1:0] hv_q, wv_q;
	// allocation memory
	logic              a_we;
	logic [AW-1:0]     a_wa, a_ra;
	logic [ADDR_W+SIZE_W-1:0] a_wd, a_rd;
	logic [MAX_ALLOCS-1:0] av_q;

	sfa_ram #(.DEPTH(MAX_HOLES), .WIDTH(ADDR_W+SIZE_W)) u_hole (
		.clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
	sfa_ram #(.DEPTH(MAX_HOLES), .WIDTH(ADDR_W+SIZE_W)) u_work (
		.clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd));
	sfa_ram #(.DEPTH(MAX_ALLOCS), .WIDTH(ADDR_W+SIZE_W)) u_alloc (
		.clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));

	// staged sizes; index MAX_GROUP holds the last request of the group
	logic              g_we;
	logic [GW-1:0]     g_wa, g_ra;
	logic [SIZE_W-1:0] g_wd, g_rd;
	sfa_ram #(.DEPTH(MAX_GROUP+1), .WIDTH(SIZE_W)) u_stage (
		.clk(clk), .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));
	// segment start addresses found during placement
	logic              sg_we;
	logic [GW-1:0]     sg_wa, sg_ra;
	logic [ADDR_W-1:0] sg_wd, sg_rd;
	sfa_ram #(.DEPTH(MAX_GROUP+1), .WIDTH(ADDR_W)) u_seg (
		.clk(clk), .we(sg_we), .waddr(sg_wa), .wdata(sg_wd), .raddr(sg_ra), .rdata(sg_rd));

	logic [SIZE_W-1:0] mem_size_q;
	logic [GW-1:0]     staged_count_q;
	req_t              req_q;
	logic [ADDR_W-1:0] s_q;
	logic [SIZE_W-1:0] z_q;
	logic [HC-1:0]     hi_q;       // scan index, hole table
	logic [AC-1:0]     ai_q;       // scan index, alloc table
	logic              rd_ok_q;    // previous cycle issued a read
	logic [HW-1:0]     rd_idx_q;
	logic [AW-1:0]     ard_idx_q;
	logic              bad_q;
	logic              lo_f_q, hi_f_q, fr_f_q;
	logic [HW-1:0]     lo_q, hi_q2;
	logic [ADDR_W-1:0] lo_s_q;
	logic [SIZE_W-1:0] lo_z_q, hi_z_q;
	logic [AW-1:0]     fr_idx_q;
	logic [GW-1:0]     n_q, seg_i_q;
	logic [SIZE_W-1:0] cur_sz_q;
	logic              best_f_q;
	logic [HW-1:0]     best_q;
	logic [ADDR_W-1:0] best_s_q;
	logic [SIZE_W-1:0] best_z_q;
	logic [HC-1:0]     copy_q;
	logic [AC-1:0]     free_cnt_q;
	logic              emit_rd_q;
	rsp_t              rsp_q;
	logic              out_v_q;

	assign in_stall  = (state_q != S_IDLE) || out_v_q;
	assign out_valid = out_v_q;
	assign out_data  = rsp_q;

	logic in_acc, out_acc;
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_v_q && !out_stall;

	logic [LW-1:0] limit;
	assign limit = ({{(LW-SIZE_W){1'b0}}, mem_size_q} < (LW'(1) << ADDR_BITS)) ?
		{{(LW-SIZE_W){1'b0}}, mem_size_q} : (LW'(1) << ADDR_BITS);

	// read data aliases
	logic [ADDR_W-1:0] hr_s, wr_s, ar_s;
	logic [SIZE_W-1:0] hr_z, wr_z, ar_z;
	assign {hr_s, hr_z} = h_rd;
	assign {wr_s, wr_z} = w_rd;
	assign {ar_s, ar_z} = a_rd;

	logic [EW-1:0] e_req, hr_end, ar_end;
	assign e_req  = EW'(s_q) + EW'(z_q);
	assign hr_end = EW'(hr_s) + EW'(hr_z);
	assign ar_end = EW'(ar_s) + EW'(ar_z);

	// first free hole entry and first free alloc entry (priority over valid bits)
	logic          h_free_f;
	logic [HW-1:0] h_free;
	always_comb begin
		h_free_f = 1'b0;
		h_free   = '0;
		for (int i = MAX_HOLES - 1; i >= 0; i--) begin
			if (!hv_q[i]) begin
				h_free_f = 1'b1;
				h_free   = HW'(i);
			end
		end
	end

	logic [AW-1:0] a_free;
	always_comb begin
		a_free = '0;
		for (int i = MAX_ALLOCS - 1; i >= 0; i--) begin
			if (!av_q[i]) begin
				a_free = AW'(i);
			end
		end
	end

	// best-choice compare for the placement scan
	logic w_fit, w_better;
	assign w_fit = wv_q[rd_idx_q] && (wr_z >= cur_sz_q);
	always_comb begin
		if (!best_f_q) begin
			w_better = 1'b1;
		end else if (req_q.policy && (wr_z != best_z_q)) begin
			w_better = wr_z < best_z_q;
		end else begin
			w_better = wr_s < best_s_q;
		end
	end

	logic [SIZE_W-1:0] new_lo_z;
	assign new_lo_z = lo_z_q + z_q + (hi_f_q ? hi_z_q : '0);

	always_comb begin
		h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = hi_q[HW-1:0];
		w_we = 1'b0; w_wa = '0; w_wd = '0; w_ra = hi_q[HW-1:0];
		a_we = 1'b0; a_wa = '0; a_wd = '0; a_ra = ai_q[AW-1:0];
		g_we = 1'b0; g_wa = staged_count_q; g_wd = in_data.size; g_ra = seg_i_q;
		sg_we = 1'b0; sg_wa = seg_i_q; sg_wd = best_s_q; sg_ra = seg_i_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && in_data.kind == KIND_SEG) begin
					if (in_data.last_of_group) begin
						g_we = 1'b1;
						g_wa = GW'(MAX_GROUP);
					end else if (staged_count_q < GW'(MAX_GROUP)) begin
						g_we = 1'b1;
					end
				end
			end
			S_INS_WR: begin
				h_we = 1'b1;
				if (lo_f_q) begin
					h_wa = lo_q; h_wd = {lo_s_q, new_lo_z};
				end else if (hi_f_q) begin
					h_wa = hi_q2; h_wd = {s_q, z_q + hi_z_q};
				end else begin
					h_wa = h_free; h_wd = {s_q, z_q};
				end
			end
			S_GRP_COPY: begin
				h_ra = copy_q[HW-1:0];
				if (rd_ok_q) begin
					w_we = 1'b1; w_wa = rd_idx_q; w_wd = h_rd;
				end
			end
			S_GRP_SEG: g_ra = (seg_i_q == n_q - GW'(1)) ? GW'(MAX_GROUP) : seg_i_q;
			S_GRP_PICK: begin
				if (hi_q == HC'(MAX_HOLES) && !rd_ok_q && best_f_q) begin
					w_we = 1'b1; w_wa = best_q;
					w_wd = {best_s_q + cur_sz_q[ADDR_W-1:0], best_z_q - cur_sz_q};
					sg_we = 1'b1;
				end
			end
			S_GRP_COMMIT: begin
				w_ra = copy_q[HW-1:0];
				if (rd_ok_q) begin
					h_we = 1'b1; h_wa = rd_idx_q; h_wd = w_rd;
				end
			end
			S_GRP_EMIT: begin
				g_ra = (seg_i_q == n_q - GW'(1)) ? GW'(MAX_GROUP) : seg_i_q;
				if (emit_rd_q && !out_v_q) begin
					a_we = 1'b1; a_wa = a_free; a_wd = {sg_rd, g_rd};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mem_size_q <= SIZE_W'(65536);
			staged_count_q <= '0;
			hv_q <= '0; wv_q <= '0; av_q <= '0;
			out_v_q <= 1'b0;
			rd_ok_q <= 1'b0;
			emit_rd_q <= 1'b0;
		end else begin
			if (cfg_we) mem_size_q <= cfg_wdata;
			if (out_acc) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						req_q <= in_data;
						s_q <= in_data.addr;
						z_q <= in_data.size;
						hi_q <= '0; ai_q <= '0; rd_ok_q <= 1'b0;
						bad_q <= 1'b0; lo_f_q <= 1'b0; hi_f_q <= 1'b0; fr_f_q <= 1'b0;
						unique case (in_data.kind)
							KIND_CLEAR: begin
								hv_q <= '0; av_q <= '0; staged_count_q <= '0;
								rsp_q <= '{ST_OK, '0, '0, 1'b1};
								state_q <= S_EMIT1;
							end
							KIND_ADD: begin
								if (in_data.size == '0 || (LW'(in_data.addr) + LW'(in_data.size))
										> limit) begin
									rsp_q <= '{ST_BADRANGE, '0, '0, 1'b1};
									state_q <= S_EMIT1;
								end else begin
									state_q <= S_AH_SCAN;
								end
							end
							KIND_FREE: state_q <= S_FR_SCAN;
							KIND_SEG: begin
								if (!in_data.last_of_group) begin
									if (staged_count_q < GW'(MAX_GROUP))
										staged_count_q <= staged_count_q + GW'(1);
								end else begin
									staged_count_q <= '0;
									n_q <= staged_count_q + GW'(1);
									free_cnt_q <= '0;
									if (staged_count_q >= GW'(MAX_GROUP)) begin
										rsp_q <= '{ST_BADRANGE, '0, '0, 1'b1};
										state_q <= S_EMIT1;
									end else begin
										bad_q <= (in_data.size == '0);
										seg_i_q <= '0;
										state_q <= S_GRP_CNT;
									end
								end
							end
							default: ;
						endcase
					end
				end
				// scan over holes: overlap check in S_AH_SCAN only; both states find merge neighbors
				S_AH_SCAN, S_INS: begin
					rd_ok_q <= (hi_q < HC'(MAX_HOLES));
					rd_idx_q <= hi_q[HW-1:0];
					if (hi_q < HC'(MAX_HOLES)) hi_q <= hi_q + HC'(1);
					if (rd_ok_q && hv_q[rd_idx_q]) begin
						if (state_q == S_AH_SCAN && hr_s < e_req[ADDR_W:0]
								&& EW'(s_q) < hr_end)
							bad_q <= 1'b1;
						if (hr_end == EW'(s_q)) begin
							lo_f_q <= 1'b1; lo_q <= rd_idx_q; lo_s_q <= hr_s; lo_z_q <= hr_z;
						end
						if (EW'(hr_s) == e_req) begin
							hi_f_q <= 1'b1; hi_q2 <= rd_idx_q; hi_z_q <= hr_z;
						end
					end
					if (!rd_ok_q && hi_q == HC'(MAX_HOLES)) begin
						if (state_q == S_AH_SCAN) begin
							ai_q <= '0;
							state_q <= S_AH_ASCAN;
						end else if (!lo_f_q && !hi_f_q && !h_free_f) begin
							rsp_q <= '{ST_FULL, '0, '0, 1'b1};
							state_q <= S_EMIT1;
						end else begin
							state_q <= S_INS_WR;
						end
					end
				end
				S_AH_ASCAN: begin
					rd_ok_q <= (ai_q < AC'(MAX_ALLOCS));
					ard_idx_q <= ai_q[AW-1:0];
					if (ai_q < AC'(MAX_ALLOCS)) ai_q <= ai_q + AC'(1);
					if (rd_ok_q && av_q[ard_idx_q] && ar_s < e_req[ADDR_W:0]
							&& EW'(s_q) < ar_end)
						bad_q <= 1'b1;
					if (!rd_ok_q && ai_q == AC'(MAX_ALLOCS)) begin
						if (bad_q) begin
							rsp_q <= '{ST_BADRANGE, '0, '0, 1'b1};
							state_q <= S_EMIT1;
						end else begin
							hi_q <= '0;
							state_q <= S_INS;
						end
					end
				end
				S_INS_WR: begin
					if (lo_f_q) begin
						if (hi_f_q) hv_q[hi_q2] <= 1'b0;
					end else if (!hi_f_q) begin
						hv_q[h_free] <= 1'b1;
					end
					if (fr_f_q) av_q[fr_idx_q] <= 1'b0;
					rsp_q <= '{ST_OK, '0, '0, 1'b1};
					state_q <= S_INS_WR2;
				end
				S_INS_WR2: state_q <= S_EMIT1;
				S_FR_SCAN: begin
					rd_ok_q <= (ai_q < AC'(MAX_ALLOCS)) && !fr_f_q;
					ard_idx_q <= ai_q[AW-1:0];
					if (ai_q < AC'(MAX_ALLOCS)) ai_q <= ai_q + AC'(1);
					if (rd_ok_q && av_q[ard_idx_q] && ar_s == s_q && !fr_f_q) begin
						fr_f_q <= 1'b1; fr_idx_q <= ard_idx_q; z_q <= ar_z;
					end
					if (!rd_ok_q && (ai_q == AC'(MAX_ALLOCS) || fr_f_q)) begin
						if (fr_f_q) begin
							hi_q <= '0;
							state_q <= S_INS;
						end else begin
							rsp_q <= '{ST_NOTFOUND, '0, '0, 1'b1};
							state_q <= S_EMIT1;
						end
					end
				end
				// count free alloc entries and check staged sizes for zero
				S_GRP_CNT: begin
					if (ai_q < AC'(MAX_ALLOCS)) begin
						if (!av_q[ai_q[AW-1:0]]) free_cnt_q <= free_cnt_q + AC'(1);
						ai_q <= ai_q + AC'(1);
					end
					rd_ok_q <= (seg_i_q < n_q - GW'(1));
					if (seg_i_q < n_q - GW'(1)) seg_i_q <= seg_i_q + GW'(1);
					if (rd_ok_q && g_rd == '0) bad_q <= 1'b1;
					if (ai_q == AC'(MAX_ALLOCS) && !rd_ok_q && seg_i_q == n_q - GW'(1)) begin
						if (bad_q) begin
							rsp_q <= '{ST_BADRANGE, '0, '0, 1'b1};
							state_q <= S_EMIT1;
						end else if (free_cnt_q < AC'(n_q)) begin
							rsp_q <= '{ST_FULL, '0, '0, 1'b1};
							state_q <= S_EMIT1;
						end else begin
							copy_q <= '0; wv_q <= hv_q;
							state_q <= S_GRP_COPY;
						end
					end
				end
				S_GRP_COPY: begin
					rd_ok_q <= (copy_q < HC'(MAX_HOLES));
					rd_idx_q <= copy_q[HW-1:0];
					if (copy_q < HC'(MAX_HOLES)) copy_q <= copy_q + HC'(1);
					if (!rd_ok_q && copy_q == HC'(MAX_HOLES)) begin
						seg_i_q <= '0;
						state_q <= S_GRP_SEG;
					end
				end
				S_GRP_SEG: state_q <= S_GRP_PICK;
				S_GRP_PICK: begin
					if (hi_q == '0 && !rd_ok_q && !best_f_q && copy_q != '0) begin
						cur_sz_q <= g_rd;
						copy_q <= '0;
					end
					if (copy_q != '0) begin
						// first cycle: latch size, start scan
						cur_sz_q <= g_rd;
						copy_q <= '0;
						best_f_q <= 1'b0;
						hi_q <= '0;
						rd_ok_q <= 1'b0;
					end else begin
						rd_ok_q <= (hi_q < HC'(MAX_HOLES));
						rd_idx_q <= hi_q[HW-1:0];
						if (hi_q < HC'(MAX_HOLES)) hi_q <= hi_q + HC'(1);
						if (rd_ok_q && w_fit && w_better) begin
							best_f_q <= 1'b1; best_q <= rd_idx_q;
							best_s_q <= wr_s; best_z_q <= wr_z;
						end
						if (!rd_ok_q && hi_q == HC'(MAX_HOLES)) begin
							if (!best_f_q) begin
								rsp_q <= '{ST_NOFIT, '0, 3'(seg_i_q), 1'b1};
								state_q <= S_EMIT1;
							end else begin
								if (best_z_q == cur_sz_q) wv_q[best_q] <= 1'b0;
								if (seg_i_q == n_q - GW'(1)) begin
									copy_q <= '0; rd_ok_q <= 1'b0;
									state_q <= S_GRP_COMMIT;
								end else begin
									seg_i_q <= seg_i_q + GW'(1);
									copy_q <= HC'(1);
									state_q <= S_GRP_SEG;
								end
							end
						end
					end
				end
				S_GRP_COMMIT: begin
					rd_ok_q <= (copy_q < HC'(MAX_HOLES));
					rd_idx_q <= copy_q[HW-1:0];
					if (copy_q < HC'(MAX_HOLES)) copy_q <= copy_q + HC'(1);
					if (!rd_ok_q && copy_q == HC'(MAX_HOLES)) begin
						hv_q <= wv_q;
						seg_i_q <= '0;
						emit_rd_q <= 1'b0;
						state_q <= S_GRP_EMIT;
					end
				end
				// one result per segment; record each in the allocation table
				S_GRP_EMIT: begin
					if (!emit_rd_q) begin
						emit_rd_q <= 1'b1;
					end else if (!out_v_q) begin
						av_q[a_free] <= 1'b1;
						rsp_q <= '{ST_OK, sg_rd, 3'(seg_i_q), seg_i_q == n_q - GW'(1)};
						out_v_q <= 1'b1;
						emit_rd_q <= 1'b0;
						if (seg_i_q == n_q - GW'(1)) state_q <= S_IDLE;
						else seg_i_q <= seg_i_q + GW'(1);
					end
				end
				S_EMIT1: begin
					if (!out_v_q) begin
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// placement start: S_GRP_SEG hands over with copy_q set nonzero
	// (left at MAX_HOLES by S_GRP_COPY, or set to 1 by S_GRP_PICK for the next segment)

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("request accepted while busy");
	a_stage_bound: assert property (@(posedge clk) disable iff (!arst_n)
		staged_count_q <= GW'(MAX_GROUP))
		else $error("staged count overflow");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("result dropped under stall");
endmodule

/* tb/segment_fit_allocator_tb.sv */
module segment_fit_allocator_tb;
	import sfa_pkg::*;

	localparam int NHOLES  = MAX_HOLES_DEF;
	localparam int NALLOCS = MAX_ALLOCS_DEF;
	localparam int NGROUP  = MAX_GROUP_DEF;
	localparam int SETTLE  = 4 * NALLOCS + 12 * NHOLES + 64;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [SIZE_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	req_t in_data;
	logic out_valid;
	logic out_stall;
	rsp_t out_data;

	segment_fit_allocator DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// Shadow copy of the allocator's tables.
	logic [16:0] lim_size;
	logic [ADDR_W-1:0] hs [NHOLES];
	logic [SIZE_W-1:0] hz [NHOLES];
	logic hv [NHOLES];
	logic [ADDR_W-1:0] as_ [NALLOCS];
	logic [SIZE_W-1:0] az [NALLOCS];
	logic av [NALLOCS];
	logic [SIZE_W-1:0] stg [NGROUP];
	int stg_n;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int sender_gap;       // cycles the sender still sits idle
	int recv_hold;        // cycles of a forced long receiver stall
	bit sender_drain;     // hold the sender until all responses are back
	int mismatches, rsp_count, req_count, cycles;
	int n_ok, n_fail;

	function automatic rsp_t mk(logic [2:0] st, logic [ADDR_W-1:0] a, logic [2:0] i,
			logic l);
		rsp_t r;
		r.status = st; r.seg_addr = a; r.seg_index = i; r.last = l;
		return r;
	endfunction

	function automatic logic ranges_touch(longint s, longint z, longint a, longint b);
		return a < s + z && s < a + b;
	endfunction

	// Return a range to the holes, merging with neighbors on either side.
	function automatic logic [2:0] merge_range(longint s, longint z);
		int lo, hi;
		longint e;
		lo = -1; hi = -1; e = s + z;
		for (int i = 0; i < NHOLES; i++) begin
			if (!hv[i]) continue;
			if (longint'(hs[i]) + hz[i] == s) lo = i;
			if (longint'(hs[i]) == e) hi = i;
		end
		if (lo >= 0 && hi >= 0) begin
			hz[lo] = hz[lo] + z + hz[hi];
			hv[hi] = 0;
		end else if (lo >= 0) begin
			hz[lo] = hz[lo] + z;
		end else if (hi >= 0) begin
			hs[hi] = s;
			hz[hi] = hz[hi] + z;
		end else begin
			for (int i = 0; i < NHOLES; i++) begin
				if (!hv[i]) begin
					hs[i] = s; hz[i] = z; hv[i] = 1;
					return ST_OK;
				end
			end
			return ST_FULL;
		end
		return ST_OK;
	endfunction

	function automatic logic [2:0] add_hole(longint s, longint z);
		if (z == 0 || s + z > lim_size) return ST_BADRANGE;
		for (int i = 0; i < NHOLES; i++)
			if (hv[i] && ranges_touch(s, z, hs[i], hz[i])) return ST_BADRANGE;
		for (int i = 0; i < NALLOCS; i++)
			if (av[i] && ranges_touch(s, z, as_[i], az[i])) return ST_BADRANGE;
		return merge_range(s, z);
	endfunction

	function automatic logic [2:0] free_alloc(logic [ADDR_W-1:0] s);
		logic [2:0] st;
		for (int i = 0; i < NALLOCS; i++) begin
			if (av[i] && as_[i] == s) begin
				st = merge_range(as_[i], az[i]);
				if (st == ST_OK) av[i] = 0;
				return st;
			end
		end
		return ST_NOTFOUND;
	endfunction

	// Place a whole group, all or nothing, against a working copy of the holes.
	task automatic place_group(logic [SIZE_W-1:0] last_sz, logic pol);
		logic [SIZE_W-1:0] sz [NGROUP+1];
		logic [ADDR_W-1:0] seg [NGROUP+1];
		logic [ADDR_W-1:0] ws [NHOLES];
		logic [SIZE_W-1:0] wz [NHOLES];
		logic wv [NHOLES];
		int n, spare, best, j;
		if (stg_n >= NGROUP) begin
			stg_n = 0;
			expected_rsps.push_back(mk(ST_BADRANGE, 0, 0, 1));
			n_fail++;
			return;
		end
		for (int i = 0; i < stg_n; i++) sz[i] = stg[i];
		sz[stg_n] = last_sz;
		n = stg_n + 1;
		stg_n = 0;
		for (int i = 0; i < n; i++) begin
			if (sz[i] == 0) begin
				expected_rsps.push_back(mk(ST_BADRANGE, 0, 0, 1));
				n_fail++;
				return;
			end
		end
		spare = 0;
		for (int i = 0; i < NALLOCS; i++) if (!av[i]) spare++;
		if (spare < n) begin
			expected_rsps.push_back(mk(ST_FULL, 0, 0, 1));
			n_fail++;
			return;
		end
		for (int i = 0; i < NHOLES; i++) begin
			ws[i] = hs[i]; wz[i] = hz[i]; wv[i] = hv[i];
		end
		for (int i = 0; i < n; i++) begin
			best = -1;
			for (int k = 0; k < NHOLES; k++) begin
				if (!wv[k] || wz[k] < sz[i]) continue;
				if (best < 0) best = k;
				else if (pol && wz[k] != wz[best]) begin
					if (wz[k] < wz[best]) best = k;
				end else if (ws[k] < ws[best]) best = k;
			end
			if (best < 0) begin
				expected_rsps.push_back(mk(ST_NOFIT, 0, 3'(i), 1));
				n_fail++;
				return;
			end
			seg[i] = ws[best];
			ws[best] = ws[best] + sz[i];
			wz[best] = wz[best] - sz[i];
			if (wz[best] == 0) wv[best] = 0;
		end
		for (int i = 0; i < NHOLES; i++) begin
			hs[i] = ws[i]; hz[i] = wz[i]; hv[i] = wv[i];
		end
		j = 0;
		for (int i = 0; i < n; i++) begin
			while (av[j]) j++;
			as_[j] = seg[i]; az[j] = sz[i]; av[j] = 1;
			expected_rsps.push_back(mk(ST_OK, seg[i], 3'(i), i + 1 == n));
		end
		n_ok++;
	endtask

	task automatic predict_request(req_t r);
		case (r.kind)
			KIND_CLEAR: begin
				for (int i = 0; i < NHOLES; i++) hv[i] = 0;
				for (int i = 0; i < NALLOCS; i++) av[i] = 0;
				stg_n = 0;
				expected_rsps.push_back(mk(ST_OK, 0, 0, 1));
			end
			KIND_ADD: expected_rsps.push_back(mk(add_hole(r.addr, r.size), 0, 0, 1));
			KIND_FREE: expected_rsps.push_back(mk(free_alloc(r.addr), 0, 0, 1));
			default: begin
				if (!r.last_of_group) begin
					if (stg_n < NGROUP) begin
						stg[stg_n] = r.size;
						stg_n++;
					end
				end else begin
					place_group(r.size, r.policy);
				end
			end
		endcase
	endtask

	function automatic req_t mkreq(logic [1:0] k, logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] z,
			logic l, logic p);
		req_t r;
		r.kind = k; r.addr = a; r.size = z; r.last_of_group = l; r.policy = p;
		return r;
	endfunction

	function automatic int pick_gap();
		int d;
		d = $urandom_range(0, 99);
		if (d < 50) return 0;
		if (d < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Driver: offer the head of the pending queue; hold it while stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			in_data <= '0;
			sender_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_request(in_data);
				req_count++;
				void'(pending_reqs.pop_front());
			end
			if (in_valid && in_stall) begin
				// hold the stalled request
			end else if (sender_gap > 0) begin
				sender_gap <= sender_gap - 1;
				in_valid <= 0;
			end else if (sender_drain || pending_reqs.size() == 0 ||
					(in_valid && !in_stall && pending_reqs.size() == 0)) begin
				in_valid <= 0;
			end else begin
				in_valid <= 1;
				in_data <= pending_reqs[0];
				sender_gap <= pick_gap();
			end
		end
	end

	// Monitor: compare each response with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				rsp_count++;
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected response %p", out_data);
				end else begin
					if (out_data !== expected_rsps[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("response %0d: expected %p got %p", rsp_count,
								expected_rsps[0], out_data);
					end
					void'(expected_rsps.pop_front());
				end
			end
			if (recv_hold > 0) begin
				recv_hold <= recv_hold - 1;
				out_stall <= 1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 25);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d responses outstanding", expected_rsps.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_mem_size(logic [SIZE_W-1:0] v);
		wait_drained();
		@(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		lim_size = (v > 65536) ? 17'd65536 : v;
	endtask

	// Random segment group of n segments, mostly small sizes.
	task automatic queue_group(int n, logic pol);
		for (int i = 0; i < n; i++)
			pending_reqs.push_back(mkreq(KIND_SEG, $urandom, (i == n - 1 && $urandom_range(0, 20) == 0) ?
				17'd0 : 17'($urandom_range(1, 700)), i == n - 1, i == n - 1 ? pol : $urandom));
	endtask

	task automatic random_phase(int count);
		int pick;
		logic [ADDR_W-1:0] a;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				a = $urandom_range(0, 31) * 512;
				pending_reqs.push_back(mkreq(KIND_ADD, a, $urandom_range(1, 600), 0, $urandom));
			end else if (pick < 45) begin
				queue_group($urandom_range(1, 4), $urandom);
			end else if (pick < 75) begin
				// free a live allocation when the draw picks one, else a random address
				a = $urandom;
				for (int i = 0; i < NALLOCS; i++)
					if (av[i] && $urandom_range(0, 2) == 0) a = as_[i];
				pending_reqs.push_back(mkreq(KIND_FREE, a, $urandom, $urandom, $urandom));
			end else if (pick < 78) begin
				queue_group($urandom_range(9, 10), $urandom);
			end else if (pick < 80) begin
				pending_reqs.push_back(mkreq(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom));
			end else if (pick < 90) begin
				pending_reqs.push_back(mkreq(KIND_ADD, $urandom, $urandom_range(0, 131071), 0, 1));
			end else begin
				pending_reqs.push_back(mkreq(KIND_SEG, $urandom, 17'h1FFFF, 1, $urandom));
			end
			// let the predictor catch up so frees target real allocations
			while (pending_reqs.size() > 4) @(posedge clk);
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		lim_size = 17'd65536;
		for (int i = 0; i < NHOLES; i++) hv[i] = 0;
		for (int i = 0; i < NALLOCS; i++) av[i] = 0;
		stg_n = 0;
		sender_drain = 0;
		recv_hold = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;

		// Directed: extremes, every kind, the listed corner cases.
		pending_reqs.push_back(mkreq(KIND_ADD, 0, 0, 0, 0));            // zero size
		pending_reqs.push_back(mkreq(KIND_ADD, 16'hFFFF, 2, 0, 0));     // past limit
		pending_reqs.push_back(mkreq(KIND_ADD, 0, 17'h10000, 0, 0));    // whole space
		pending_reqs.push_back(mkreq(KIND_ADD, 100, 10, 0, 0));         // overlap
		pending_reqs.push_back(mkreq(KIND_SEG, 0, 16, 0, 0));
		pending_reqs.push_back(mkreq(KIND_SEG, 0, 32, 1, 0));           // first fit
		pending_reqs.push_back(mkreq(KIND_FREE, 16'h1234, 0, 0, 0));    // unknown start
		pending_reqs.push_back(mkreq(KIND_FREE, 0, 0, 0, 0));
		pending_reqs.push_back(mkreq(KIND_SEG, 0, 0, 1, 1));            // zero segment
		pending_reqs.push_back(mkreq(KIND_SEG, 0, 17'h1FFFF, 1, 1));    // no fit
		pending_reqs.push_back(mkreq(KIND_CLEAR, 16'hFFFF, 17'h1FFFF, 1, 1));
		for (int i = 0; i < 4; i++)
			pending_reqs.push_back(mkreq(KIND_ADD, 16'(i * 1000), 17'(400 - i * 90), 0, 0));
		pending_reqs.push_back(mkreq(KIND_SEG, 0, 50, 1, 1));           // best fit
		for (int i = 0; i < 9; i++)                                    // group too long
			pending_reqs.push_back(mkreq(KIND_SEG, 0, 1, i == 8, 0));
		wait_drained();

		// Hole table full: scatter isolated holes.
		pending_reqs.push_back(mkreq(KIND_CLEAR, 0, 0, 0, 0));
		for (int i = 0; i < NHOLES + 2; i++)
			pending_reqs.push_back(mkreq(KIND_ADD, 16'(i * 64), 8, 0, 0));
		// Allocation table full: many single-unit groups.
		for (int i = 0; i < NALLOCS + 2; i++)
			pending_reqs.push_back(mkreq(KIND_SEG, 0, 1, 1, i[0]));

		// Long receiver stall while the sender keeps offering.
		recv_hold = 400;
		random_phase(20);

		write_mem_size(17'd0);
		pending_reqs.push_back(mkreq(KIND_CLEAR, 0, 0, 0, 0));
		pending_reqs.push_back(mkreq(KIND_ADD, 0, 1, 0, 0));
		write_mem_size(17'd1);
		pending_reqs.push_back(mkreq(KIND_ADD, 0, 1, 0, 0));
		pending_reqs.push_back(mkreq(KIND_SEG, 0, 1, 1, 0));
		write_mem_size(17'h1FFFF);
		pending_reqs.push_back(mkreq(KIND_CLEAR, 0, 0, 0, 0));
		random_phase(70);

		// Sender pauses until every response has come back.
		sender_drain = 1;
		wait (expected_rsps.size() == 0 && !in_valid);
		sender_drain = 0;

		write_mem_size(17'd4096);   // shrink below existing holes
		random_phase(60);
		write_mem_size(17'd65536);
		pending_reqs.push_back(mkreq(KIND_CLEAR, 0, 0, 0, 0));
		random_phase(70);
		wait_drained();

		$display("covered %0d requests and %0d responses, %0d groups placed, %0d groups refused",
			req_count, rsp_count, n_ok, n_fail);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/sfa_pkg.sv
sv/sfa_ram.sv
sv/segment_fit_allocator.sv
tb/segment_fit_allocator_tb.sv
